// ===== rtl/core/stm_pkg.sv =====
// Shared constants for the top-of-stack register manager.
// Holds operation codes, configuration register indexes and reset values.
// No dependencies.
package stm_pkg;

	// Default sizes of the stack memory and of one word.
	localparam int ADDRESS_BITS_DEF = 15;
	localparam int WORD_BITS_DEF    = 48;

	// Limit register width and the stack pointer shift it is compared against.
	localparam int LIMIT_BITS  = 9;
	localparam int LIMIT_SHIFT = 6;
	localparam logic [LIMIT_BITS-1:0] STACK_LIMIT_RESET = 9'd511;

	// Operation codes carried on the slave-side tuser.
	localparam int FUNC_BITS = 4;
	localparam logic [FUNC_BITS-1:0] FUNC_FILL_AB   = 4'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_FILL_A    = 4'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_FILL_B    = 4'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_EMPTY_AB  = 4'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_EMPTY_A   = 4'd4;
	localparam logic [FUNC_BITS-1:0] FUNC_EMPTY_B   = 4'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_EXCHANGE  = 4'd6;
	localparam logic [FUNC_BITS-1:0] FUNC_LOAD_A    = 4'd7;
	localparam logic [FUNC_BITS-1:0] FUNC_LOAD_B    = 4'd8;
	localparam logic [FUNC_BITS-1:0] FUNC_SET_S     = 4'd9;
	localparam logic [FUNC_BITS-1:0] FUNC_MEM_WRITE = 4'd10;
	localparam logic [FUNC_BITS-1:0] FUNC_MEM_READ  = 4'd11;
	localparam logic [FUNC_BITS-1:0] FUNC_CLR_FLAGS = 4'd12;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STACK_LIMIT  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_STATE = 1'd1;

endpackage

// ===== rtl/core/stack_top_register_manager.sv =====
// Top-of-stack register manager: registers A and B with full flags, spilling
// to and filling from a single-port word memory addressed by the stack pointer.
// Depends on stm_pkg for operation codes, register indexes and reset values.
// Sequence: each memory access of a fill or spill takes its own ST_EXEC step,
// every read then waits in ST_WAIT for its registered data, and ST_OUT loads
// the result once the result register is free; only then is a new beat taken.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the memory
// one word per cycle before tready.
module stack_top_register_manager #(
	parameter int ADDRESS_BITS = stm_pkg::ADDRESS_BITS_DEF,
	parameter int WORD_BITS    = stm_pkg::WORD_BITS_DEF,
	localparam int IN_W  = ((WORD_BITS + ADDRESS_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * WORD_BITS + ADDRESS_BITS + 4 + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input beat.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [IN_W-1:0]                     s_tdata,  // value, address
	input  logic [stm_pkg::FUNC_BITS-1:0]       s_tuser,  // func
	// Result beat.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// top_a, top_b, a_full, b_full, stack_pointer, overflow_flag,
	// interrupt_raised, read_data
	output logic [OUT_W-1:0]                    m_tdata,
	// Configuration writes.
	input  logic                                cfg_we,
	input  logic [stm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [stm_pkg::LIMIT_BITS-1:0]      cfg_data
);

	localparam int DEPTH   = 2 ** ADDRESS_BITS;
	localparam int HI_BITS = ADDRESS_BITS - stm_pkg::LIMIT_SHIFT;
	localparam int CMP_W   = (HI_BITS > stm_pkg::LIMIT_BITS) ? HI_BITS : stm_pkg::LIMIT_BITS;
	localparam int OVF_POS = 2 * WORD_BITS + ADDRESS_BITS + 2;
	localparam int IRQ_POS = 2 * WORD_BITS + ADDRESS_BITS + 3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_MOVE_BA,
		ACT_MOVE_AB,
		ACT_SWAP,
		ACT_FILL_A,
		ACT_FILL_A_MV,
		ACT_FILL_B,
		ACT_SPILL_A,
		ACT_SPILL_B,
		ACT_LOAD_A,
		ACT_LOAD_B,
		ACT_SET_S,
		ACT_MEM_WR,
		ACT_MEM_RD,
		ACT_CLR_FLAGS
	} act_t;

	typedef enum logic [1:0] {
		TGT_A,
		TGT_B,
		TGT_RD
	} tgt_t;

	state_t                            state_q;
	logic [ADDRESS_BITS-1:0]           clr_q;
	logic [stm_pkg::FUNC_BITS-1:0]     func_q;
	logic [WORD_BITS-1:0]              value_q;
	logic [ADDRESS_BITS-1:0]           addr_q;
	logic [WORD_BITS-1:0]              reg_a_q;
	logic [WORD_BITS-1:0]              reg_b_q;
	logic                              fa_q;
	logic                              fb_q;
	logic [ADDRESS_BITS-1:0]           sp_q;
	logic                              ovf_q;
	logic                              irq_q;
	logic [WORD_BITS-1:0]              rd_q;
	logic [stm_pkg::LIMIT_BITS-1:0]    limit_q;
	logic                              normal_q;
	tgt_t                              tgt_q;
	logic                              last_q;
	logic                              m_tvalid_q;
	logic [OUT_W-1:0]                  m_tdata_q;

	logic [WORD_BITS-1:0]              mem [DEPTH];
	logic [WORD_BITS-1:0]              rdata_q;

	act_t                              act;
	logic                              act_last;
	logic                              act_read;
	logic                              act_spill;
	logic                              sp_dec;
	logic [ADDRESS_BITS-1:0]           sp_step;
	logic                              ovf_hit;
	logic [CMP_W-1:0]                  sp_hi_ext;
	logic [CMP_W-1:0]                  limit_ext;
	logic                              mem_we;
	logic [ADDRESS_BITS-1:0]           mem_addr;
	logic [WORD_BITS-1:0]              mem_wdata;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Next step of the current operation, chosen from the live full flags.
	always_comb begin
		act      = ACT_NOP;
		act_last = 1'b1;
		case (func_q)
			stm_pkg::FUNC_FILL_AB: begin
				if (fa_q && fb_q) begin
					act = ACT_NOP;
				end else if (fb_q) begin
					act      = ACT_MOVE_BA;
					act_last = 1'b0;
				end else if (!fa_q) begin
					act      = ACT_FILL_A;
					act_last = 1'b0;
				end else begin
					act = ACT_FILL_B;
				end
			end
			stm_pkg::FUNC_FILL_A: begin
				if (!fa_q && fb_q) begin
					act = ACT_MOVE_BA;
				end else if (!fa_q) begin
					act = ACT_FILL_A;
				end
			end
			stm_pkg::FUNC_FILL_B: begin
				if (!fb_q) begin
					act = ACT_FILL_B;
				end
			end
			stm_pkg::FUNC_EMPTY_AB: begin
				if (fb_q) begin
					act      = ACT_SPILL_B;
					act_last = !fa_q;
				end else if (fa_q) begin
					act = ACT_SPILL_A;
				end
			end
			stm_pkg::FUNC_EMPTY_A: begin
				if (fa_q && fb_q) begin
					act      = ACT_SPILL_B;
					act_last = 1'b0;
				end else if (fa_q) begin
					act = ACT_MOVE_AB;
				end
			end
			stm_pkg::FUNC_EMPTY_B: begin
				if (fb_q) begin
					act = ACT_SPILL_B;
				end
			end
			stm_pkg::FUNC_EXCHANGE: begin
				if (fa_q && fb_q) begin
					act = ACT_SWAP;
				end else if (fa_q) begin
					act = ACT_FILL_A_MV;
				end else if (fb_q) begin
					act = ACT_FILL_A;
				end else begin
					act      = ACT_FILL_B;
					act_last = 1'b0;
				end
			end
			stm_pkg::FUNC_LOAD_A:    act = ACT_LOAD_A;
			stm_pkg::FUNC_LOAD_B:    act = ACT_LOAD_B;
			stm_pkg::FUNC_SET_S:     act = ACT_SET_S;
			stm_pkg::FUNC_MEM_WRITE: act = ACT_MEM_WR;
			stm_pkg::FUNC_MEM_READ:  act = ACT_MEM_RD;
			stm_pkg::FUNC_CLR_FLAGS: act = ACT_CLR_FLAGS;
			default:                 act = ACT_NOP;
		endcase
	end

	assign sp_dec    = (act == ACT_FILL_A) || (act == ACT_FILL_A_MV) || (act == ACT_FILL_B);
	assign act_read  = sp_dec || (act == ACT_MEM_RD);
	assign act_spill = (act == ACT_SPILL_A) || (act == ACT_SPILL_B);

	// Shared stack pointer unit: one incrementer/decrementer and the limit compare.
	assign sp_step   = sp_q + (sp_dec ? {ADDRESS_BITS{1'b1}} : ADDRESS_BITS'(1));
	assign sp_hi_ext = CMP_W'(sp_q >> stm_pkg::LIMIT_SHIFT);
	assign limit_ext = CMP_W'(limit_q);
	assign ovf_hit   = normal_q && (sp_hi_ext == limit_ext);

	// Memory port selection for the clearing pass and the current step.
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = sp_q;
		mem_wdata = reg_a_q;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_q;
			mem_wdata = '0;
		end else if (state_q == ST_EXEC) begin
			case (act)
				ACT_SPILL_A: begin
					mem_we    = !ovf_hit;
					mem_addr  = sp_step;
					mem_wdata = reg_a_q;
				end
				ACT_SPILL_B: begin
					mem_we    = !ovf_hit;
					mem_addr  = sp_step;
					mem_wdata = reg_b_q;
				end
				ACT_MEM_WR: begin
					mem_we    = 1'b1;
					mem_addr  = addr_q;
					mem_wdata = value_q;
				end
				ACT_MEM_RD: begin
					mem_addr = addr_q;
				end
				default: begin
					mem_addr = sp_q;
				end
			endcase
		end
	end

	// Word memory with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	// Sequencer, architectural registers, configuration and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			func_q     <= '0;
			value_q    <= '0;
			addr_q     <= '0;
			reg_a_q    <= '0;
			reg_b_q    <= '0;
			fa_q       <= 1'b0;
			fb_q       <= 1'b0;
			sp_q       <= '0;
			ovf_q      <= 1'b0;
			irq_q      <= 1'b0;
			rd_q       <= '0;
			limit_q    <= stm_pkg::STACK_LIMIT_RESET;
			normal_q   <= 1'b1;
			tgt_q      <= TGT_A;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// Configuration writes are taken in any state.
			if (cfg_we) begin
				case (cfg_index)
					stm_pkg::CFG_STACK_LIMIT:  limit_q  <= cfg_data;
					stm_pkg::CFG_NORMAL_STATE: normal_q <= cfg_data[0];
					default: ;
				endcase
			end

			// A taken beat empties the result register; in ST_OUT the output
			// step below either reloads it or leaves it waiting.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDRESS_BITS'(1);
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						func_q  <= s_tuser;
						value_q <= s_tdata[WORD_BITS-1:0];
						addr_q  <= s_tdata[WORD_BITS +: ADDRESS_BITS];
						irq_q   <= 1'b0;
						rd_q    <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (act)
						ACT_MOVE_BA: begin
							reg_a_q <= reg_b_q;
							fa_q    <= 1'b1;
							fb_q    <= 1'b0;
						end
						ACT_MOVE_AB: begin
							reg_b_q <= reg_a_q;
							fa_q    <= 1'b0;
							fb_q    <= 1'b1;
						end
						ACT_SWAP: begin
							reg_a_q <= reg_b_q;
							reg_b_q <= reg_a_q;
						end
						ACT_FILL_A: begin
							fa_q  <= 1'b1;
							sp_q  <= sp_step;
							tgt_q <= TGT_A;
						end
						ACT_FILL_A_MV: begin
							reg_b_q <= reg_a_q;
							fb_q    <= 1'b1;
							fa_q    <= 1'b1;
							sp_q    <= sp_step;
							tgt_q   <= TGT_A;
						end
						ACT_FILL_B: begin
							fb_q  <= 1'b1;
							sp_q  <= sp_step;
							tgt_q <= TGT_B;
						end
						ACT_SPILL_A, ACT_SPILL_B: begin
							if (act == ACT_SPILL_A) begin
								fa_q <= 1'b0;
							end else begin
								fb_q <= 1'b0;
							end
							// On overflow the word is dropped and S holds.
							if (ovf_hit) begin
								ovf_q <= 1'b1;
								irq_q <= 1'b1;
							end else begin
								sp_q <= sp_step;
							end
						end
						ACT_LOAD_A: begin
							reg_a_q <= value_q;
							fa_q    <= 1'b1;
						end
						ACT_LOAD_B: begin
							reg_b_q <= value_q;
							fb_q    <= 1'b1;
						end
						ACT_SET_S: begin
							sp_q <= addr_q;
						end
						ACT_MEM_RD: begin
							tgt_q <= TGT_RD;
						end
						ACT_CLR_FLAGS: begin
							fa_q <= 1'b0;
							fb_q <= 1'b0;
						end
						default: ;
					endcase
					if (act_read) begin
						last_q  <= act_last;
						state_q <= ST_WAIT;
					end else if (act_last) begin
						state_q <= ST_OUT;
					end
				end
				ST_WAIT: begin
					// Read data of the previous step lands in its target.
					case (tgt_q)
						TGT_A:   reg_a_q <= rdata_q;
						TGT_B:   reg_b_q <= rdata_q;
						TGT_RD:  rd_q    <= rdata_q;
						default: rd_q    <= rdata_q;
					endcase
					state_q <= last_q ? ST_OUT : ST_EXEC;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_W'({rd_q, irq_q, ovf_q, sp_q, fb_q, fa_q,
							reg_b_q, reg_a_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A spill that hits the limit keeps S and flags the interrupt.
	a_ovf_keeps_sp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && act_spill && ovf_hit) |=> (sp_q == $past(sp_q)) && irq_q)
		else $error("stack pointer moved on an overflowing spill");

	// A result that reports an interrupt also shows the sticky overflow bit.
	a_irq_implies_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (!m_tdata_q[IRQ_POS] || m_tdata_q[OVF_POS]))
		else $error("interrupt reported without overflow flag");

	// The overflow bit is sticky until reset.
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ovf_q))
		else $error("overflow bit cleared");

endmodule

// ===== tb/sv/tb_stack_top_register_manager.sv =====
// Self-checking testbench for stack_top_register_manager.
// Drives operation beats, predicts each result beat from a local model of the
// stack registers and memory, and compares them field by field. Uses stm_pkg.
module tb_stack_top_register_manager;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADDR_W = 15;
	localparam int WORD_W = 48;
	localparam logic [WORD_W-1:0] WORD_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [stm_pkg::FUNC_BITS-1:0] FUNC_UNUSED_LO = 4'd13;
	localparam logic [stm_pkg::FUNC_BITS-1:0] FUNC_UNUSED_HI = 4'd15;
	localparam int NUM_PHASES = 5;
	localparam int RANDOM_PER_PHASE = 375;
	localparam int HOLDOFF_START = 700;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int CYCLE_LIMIT = 300000;

	// One result beat as seen on m_tdata.
	typedef struct packed {
		logic [WORD_W-1:0] top_a;
		logic [WORD_W-1:0] top_b;
		logic              a_full;
		logic              b_full;
		logic [ADDR_W-1:0] stack_pointer;
		logic              overflow_flag;
		logic              interrupt_raised;
		logic [WORD_W-1:0] read_data;
	} tos_result_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic [stm_pkg::FUNC_BITS-1:0] fn;
		logic [WORD_W-1:0]    val;
		logic [ADDR_W-1:0]    adr;
		bit                   typed;
		tos_result_t          want;
	} op_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata = '0;  // value [47:0], address [62:48]
	logic [3:0]        s_tuser = '0;  // func [3:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	// top_a, top_b, a_full, b_full, stack_pointer, overflow_flag,
	// interrupt_raised, read_data
	logic [167:0]      m_tdata;
	logic              cfg_we = 1'b0;
	logic [stm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [stm_pkg::LIMIT_BITS-1:0]     cfg_data = '0;

	// Local copy of the block's state and configuration.
	logic [WORD_W-1:0] pred_a, pred_b;
	logic              pred_full_a, pred_full_b;
	logic [ADDR_W-1:0] pred_sp;
	logic              pred_ovf, pred_irq;
	bit   [WORD_W-1:0] pred_mem [0:(1<<ADDR_W)-1];
	logic [stm_pkg::LIMIT_BITS-1:0] cfg_limit;
	logic              cfg_normal;

	tos_result_t expected_tos_q[$];
	op_row_t     dir_rows[$];

	bit no_idle = 1'b0;
	int n_items = 0;
	int n_results = 0;
	int n_irq = 0;
	int n_errors = 0;
	int hold_cnt = 0;
	bit holdoff_done = 1'b0;
	int cycle_cnt = 0;

	stack_top_register_manager uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 10 ns clock.
	always #5 clk = ~clk;

	// Spill one word: overflow check first, then push at the incremented pointer.
	function automatic void spill_word(input logic [WORD_W-1:0] w);
		if (pred_sp[ADDR_W-1:stm_pkg::LIMIT_SHIFT] == cfg_limit && cfg_normal) begin
			pred_ovf = 1'b1;
			pred_irq = 1'b1;
		end else begin
			pred_sp = pred_sp + 15'd1;
			pred_mem[pred_sp] = w;
		end
	endfunction

	// Fill one word from the pointer, then decrement it.
	function automatic logic [WORD_W-1:0] fill_word();
		logic [WORD_W-1:0] w;
		w = pred_mem[pred_sp];
		pred_sp = pred_sp - 15'd1;
		return w;
	endfunction

	// Apply one operation to the local state and return the result it causes.
	function automatic tos_result_t tos_predict(input logic [stm_pkg::FUNC_BITS-1:0] fn,
			input logic [WORD_W-1:0] val, input logic [ADDR_W-1:0] adr);
		tos_result_t r;
		logic [WORD_W-1:0] t;
		r = '0;
		pred_irq = 1'b0;
		case (fn)
		stm_pkg::FUNC_FILL_AB: begin
			if (pred_full_a) begin
				if (!pred_full_b) begin
					pred_b = fill_word();
					pred_full_b = 1'b1;
				end
			end else begin
				if (pred_full_b) pred_a = pred_b;
				else pred_a = fill_word();
				pred_full_a = 1'b1;
				pred_b = fill_word();
				pred_full_b = 1'b1;
			end
		end
		stm_pkg::FUNC_FILL_A: begin
			if (!pred_full_a) begin
				if (pred_full_b) begin
					pred_a = pred_b;
					pred_full_b = 1'b0;
				end else begin
					pred_a = fill_word();
				end
				pred_full_a = 1'b1;
			end
		end
		stm_pkg::FUNC_FILL_B: begin
			if (!pred_full_b) begin
				pred_b = fill_word();
				pred_full_b = 1'b1;
			end
		end
		stm_pkg::FUNC_EMPTY_AB: begin
			if (pred_full_b) begin
				spill_word(pred_b);
				pred_full_b = 1'b0;
			end
			if (pred_full_a) begin
				spill_word(pred_a);
				pred_full_a = 1'b0;
			end
		end
		stm_pkg::FUNC_EMPTY_A: begin
			// A moves down to B, which is then marked full.
			if (pred_full_a) begin
				if (pred_full_b) spill_word(pred_b);
				pred_b = pred_a;
				pred_full_a = 1'b0;
				pred_full_b = 1'b1;
			end
		end
		stm_pkg::FUNC_EMPTY_B: begin
			if (pred_full_b) begin
				spill_word(pred_b);
				pred_full_b = 1'b0;
			end
		end
		stm_pkg::FUNC_EXCHANGE: begin
			if (pred_full_a && pred_full_b) begin
				t = pred_a;
				pred_a = pred_b;
				pred_b = t;
			end else if (pred_full_a) begin
				pred_b = pred_a;
				pred_a = fill_word();
			end else if (pred_full_b) begin
				pred_a = fill_word();
			end else begin
				pred_b = fill_word();
				pred_a = fill_word();
			end
			pred_full_a = 1'b1;
			pred_full_b = 1'b1;
		end
		stm_pkg::FUNC_LOAD_A: begin
			pred_a = val;
			pred_full_a = 1'b1;
		end
		stm_pkg::FUNC_LOAD_B: begin
			pred_b = val;
			pred_full_b = 1'b1;
		end
		stm_pkg::FUNC_SET_S: pred_sp = adr;
		stm_pkg::FUNC_MEM_WRITE: pred_mem[adr] = val;
		stm_pkg::FUNC_MEM_READ: r.read_data = pred_mem[adr];
		stm_pkg::FUNC_CLR_FLAGS: begin
			pred_full_a = 1'b0;
			pred_full_b = 1'b0;
		end
		default: ;
		endcase
		r.top_a = pred_a;
		r.top_b = pred_b;
		r.a_full = pred_full_a;
		r.b_full = pred_full_b;
		r.stack_pointer = pred_sp;
		r.overflow_flag = pred_ovf;
		r.interrupt_raised = pred_irq;
		return r;
	endfunction

	function automatic tos_result_t tos_view(input logic [WORD_W-1:0] a, b,
			input logic fa, fb, input logic [ADDR_W-1:0] sp, input logic ovf, irq,
			input logic [WORD_W-1:0] rd);
		tos_result_t r;
		r.top_a = a;
		r.top_b = b;
		r.a_full = fa;
		r.b_full = fb;
		r.stack_pointer = sp;
		r.overflow_flag = ovf;
		r.interrupt_raised = irq;
		r.read_data = rd;
		return r;
	endfunction

	function automatic void add_row(input logic [stm_pkg::FUNC_BITS-1:0] fn,
			input logic [WORD_W-1:0] val, input logic [ADDR_W-1:0] adr,
			input bit typed, input tos_result_t want);
		op_row_t row;
		row.fn = fn;
		row.val = val;
		row.adr = adr;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void check_field(input string name,
			input logic [WORD_W-1:0] want, input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			n_errors++;
		end
	endfunction

	// Write both configuration registers while no operation is in flight.
	task automatic set_config(input logic [stm_pkg::LIMIT_BITS-1:0] lim, input logic nrm);
		cfg_we <= 1'b1;
		cfg_index <= stm_pkg::CFG_STACK_LIMIT;
		cfg_data <= lim;
		@(negedge clk);
		cfg_index <= stm_pkg::CFG_NORMAL_STATE;
		cfg_data <= {{(stm_pkg::LIMIT_BITS-1){1'b0}}, nrm};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_limit = lim;
		cfg_normal = nrm;
	endtask

	// Offer one operation beat, optionally after a random gap; record its result.
	task automatic send_item(input logic [stm_pkg::FUNC_BITS-1:0] fn,
			input logic [WORD_W-1:0] val, input logic [ADDR_W-1:0] adr,
			input bit typed, input tos_result_t want);
		tos_result_t r;
		if (!no_idle && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {1'b0, adr, val};
		do @(posedge clk); while (!s_tready);
		r = tos_predict(fn, val, adr);
		expected_tos_q.push_back(typed ? want : r);
		n_items++;
		@(negedge clk);
	endtask

	// Receiver: random stalls plus one long hold-off once traffic is flowing.
	always @(negedge clk) begin
		if (!holdoff_done && n_items >= HOLDOFF_START) begin
			hold_cnt = HOLDOFF_CYCLES;
			holdoff_done = 1'b1;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 13);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : result_check
		tos_result_t want;
		tos_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.top_a = m_tdata[47:0];
			got.top_b = m_tdata[95:48];
			got.a_full = m_tdata[96];
			got.b_full = m_tdata[97];
			got.stack_pointer = m_tdata[112:98];
			got.overflow_flag = m_tdata[113];
			got.interrupt_raised = m_tdata[114];
			got.read_data = m_tdata[162:115];
			n_results++;
			if (got.interrupt_raised) n_irq++;
			if (expected_tos_q.size() == 0) begin
				$error("result beat with no expectation pending");
				n_errors++;
			end else begin
				want = expected_tos_q.pop_front();
				check_field("top_a", want.top_a, got.top_a);
				check_field("top_b", want.top_b, got.top_b);
				check_field("a_full", 48'(want.a_full), 48'(got.a_full));
				check_field("b_full", 48'(want.b_full), 48'(got.b_full));
				check_field("stack_pointer", 48'(want.stack_pointer),
					48'(got.stack_pointer));
				check_field("overflow_flag", 48'(want.overflow_flag),
					48'(got.overflow_flag));
				check_field("interrupt_raised", 48'(want.interrupt_raised),
					48'(got.interrupt_raised));
				check_field("read_data", want.read_data, got.read_data);
			end
		end
	end

	// Watchdog; allows for the memory clearing pass after reset.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$error("timeout with %0d results outstanding", expected_tos_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [stm_pkg::LIMIT_BITS-1:0] phase_limit [NUM_PHASES];
		logic                  phase_norm [NUM_PHASES];
		logic [stm_pkg::FUNC_BITS-1:0]  fn;
		logic [WORD_W-1:0]     val;
		logic [ADDR_W-1:0]     adr;
		bit   [63:0]           wide;
		int                    r;

		pred_a = '0;
		pred_b = '0;
		pred_full_a = 1'b0;
		pred_full_b = 1'b0;
		pred_sp = '0;
		pred_ovf = 1'b0;
		pred_irq = 1'b0;
		cfg_limit = stm_pkg::STACK_LIMIT_RESET;
		cfg_normal = 1'b1;

		// Settings: reset values, limit 0, check disabled at limit 511, a mid limit, check disabled at limit 0.
		phase_limit[0] = stm_pkg::STACK_LIMIT_RESET; phase_norm[0] = 1'b1;
		phase_limit[1] = 9'd0;              phase_norm[1] = 1'b1;
		phase_limit[2] = 9'd511;            phase_norm[2] = 1'b0;
		phase_limit[3] = 9'($urandom_range(1, 510)); phase_norm[3] = 1'b1;
		phase_limit[4] = 9'd0;              phase_norm[4] = 1'b0;

		// Directed table: typed rows are plain to read off, the rest are predicted.
		add_row(FUNC_UNUSED_HI, WORD_MAX, 15'h7FFF, 1'b1,
			tos_view('0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0));
		add_row(stm_pkg::FUNC_LOAD_A, WORD_MAX, 15'h7FFF, 1'b1,
			tos_view(WORD_MAX, '0, 1'b1, 1'b0, '0, 1'b0, 1'b0, '0));
		add_row(stm_pkg::FUNC_LOAD_B, '0, '0, 1'b1,
			tos_view(WORD_MAX, '0, 1'b1, 1'b1, '0, 1'b0, 1'b0, '0));
		add_row(stm_pkg::FUNC_EXCHANGE, '0, '0, 1'b1,
			tos_view('0, WORD_MAX, 1'b1, 1'b1, '0, 1'b0, 1'b0, '0));
		add_row(stm_pkg::FUNC_SET_S, '0, 15'h7FFF, 1'b1,
			tos_view('0, WORD_MAX, 1'b1, 1'b1, 15'h7FFF, 1'b0, 1'b0, '0));
		// Pointer sits at the limit: both spills are dropped with an interrupt.
		add_row(stm_pkg::FUNC_EMPTY_AB, '0, '0, 1'b1,
			tos_view('0, WORD_MAX, 1'b0, 1'b0, 15'h7FFF, 1'b1, 1'b1, '0));
		add_row(stm_pkg::FUNC_MEM_WRITE, WORD_MAX, 15'h7FFF, 1'b1,
			tos_view('0, WORD_MAX, 1'b0, 1'b0, 15'h7FFF, 1'b1, 1'b0, '0));
		add_row(stm_pkg::FUNC_MEM_READ, '0, 15'h7FFF, 1'b1,
			tos_view('0, WORD_MAX, 1'b0, 1'b0, 15'h7FFF, 1'b1, 1'b0, WORD_MAX));
		// Never-written word reads back cleared.
		add_row(stm_pkg::FUNC_MEM_READ, WORD_MAX, 15'h0000, 1'b1,
			tos_view('0, WORD_MAX, 1'b0, 1'b0, 15'h7FFF, 1'b1, 1'b0, '0));
		add_row(stm_pkg::FUNC_FILL_A, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_FILL_B, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EMPTY_A, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_SET_S, '0, 15'h0000, 1'b0, '0);
		add_row(stm_pkg::FUNC_FILL_AB, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_CLR_FLAGS, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EXCHANGE, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EMPTY_B, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_SET_S, '0, 15'h7FBF, 1'b0, '0);
		add_row(stm_pkg::FUNC_EMPTY_AB, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_FILL_AB, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EXCHANGE, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EMPTY_A, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_FILL_A, '0, '0, 1'b0, '0);
		add_row(stm_pkg::FUNC_EXCHANGE, '0, '0, 1'b0, '0);
		add_row(FUNC_UNUSED_LO, 48'h5555_AAAA_5555, 15'h2AAA, 1'b0, '0);

		// Hold reset, then release it on a falling edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				while (expected_tos_q.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			set_config(phase_limit[ph], phase_norm[ph]);
			no_idle = (ph == 2);
			if (ph == 0) begin
				foreach (dir_rows[i])
					send_item(dir_rows[i].fn, dir_rows[i].val, dir_rows[i].adr,
						dir_rows[i].typed, dir_rows[i].want);
			end

			// Mostly stack traffic, with pointer moves near the limit to hit overflow.
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				wide = {$urandom(), $urandom()};
				val = wide[WORD_W-1:0];
				r = $urandom_range(0, 99);
				if (r < 5) val = '0;
				else if (r < 10) val = WORD_MAX;
				adr = 15'($urandom_range(0, (1 << ADDR_W) - 1));
				r = $urandom_range(0, 99);
				if (r < 55) begin
					fn = 4'($urandom_range(stm_pkg::FUNC_FILL_AB, stm_pkg::FUNC_EXCHANGE));
				end else if (r < 63) begin
					fn = ($urandom_range(0, 1) != 0) ? stm_pkg::FUNC_LOAD_A
						: stm_pkg::FUNC_LOAD_B;
				end else if (r < 71) begin
					fn = stm_pkg::FUNC_SET_S;
					if ($urandom_range(0, 1) != 0)
						adr = {cfg_limit, 6'($urandom_range(0, 63))};
				end else if (r < 91) begin
					fn = (r < 81) ? stm_pkg::FUNC_MEM_WRITE : stm_pkg::FUNC_MEM_READ;
					if ($urandom_range(0, 1) != 0)
						adr = pred_sp ^ 15'($urandom_range(0, 3));
				end else if (r < 96) begin
					fn = stm_pkg::FUNC_CLR_FLAGS;
				end else begin
					fn = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
				end
				send_item(fn, val, adr, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		// Drain, then allow the block's latency before the verdict.
		while (expected_tos_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d operations over %0d limit settings; checked %0d result beats.",
			n_items, NUM_PHASES, n_results);
		$display("Overflow interrupts observed: %0d; one output stall of %0d cycles.",
			n_irq, HOLDOFF_CYCLES);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/stm_pkg.sv
rtl/core/stack_top_register_manager.sv
tb/sv/tb_stack_top_register_manager.sv
